// ===== rtl/sscon_pkg.sv =====
// ----------------------------------------------------------------------------
// sscon_pkg
// Types, widths and helpers shared by the sphere pair contact pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package sscon_pkg;

   localparam int COORD_W   = 32;
   localparam int RADIUS_W  = 31;
   localparam int MAG_W     = 32;
   localparam int SQ_W      = 2 * MAG_W;
   localparam int ROOT_W    = SQ_W / 2;
   localparam int SCALED_W  = 31;
   localparam int QUOT_W    = 31;
   localparam int SHIFT_W   = 5;

   typedef struct packed {
      logic [2:0][MAG_W-1:0]   mag;
      logic [2:0]              neg;
      logic [2:0][COORD_W-1:0] ctc;
      logic [MAG_W-1:0]        rsum;
   } st1_type;

   typedef struct packed {
      logic [2:0][SQ_W-1:0]    sq;
      logic [SQ_W-1:0]         rsq;
      logic [2:0][MAG_W-1:0]   mag;
      logic [MAG_W-1:0]        mx;
      logic [2:0]              neg;
      logic [2:0][COORD_W-1:0] ctc;
      logic [MAG_W-1:0]        rsum;
   } st2_type;

   typedef struct packed {
      logic [SQ_W+1:0]         lo;
      logic [SQ_W-1:0]         rsq;
      logic [2:0][MAG_W-1:0]   mag;
      logic [SHIFT_W-1:0]      up;
      logic                    down;
      logic                    mxnz;
      logic [2:0]              neg;
      logic [2:0][COORD_W-1:0] ctc;
      logic [MAG_W-1:0]        rsum;
   } st3_type;

   typedef struct packed {
      logic                     hit;
      logic [SQ_W-1:0]          lo;
      logic [2:0][SCALED_W-1:0] c;
      logic                     mxnz;
      logic [2:0]               neg;
      logic [2:0][COORD_W-1:0]  ctc;
      logic [MAG_W-1:0]         rsum;
   } st4_type;

   typedef struct packed {
      logic                       hit;
      logic [SQ_W-1:0]            lo;
      logic [2:0][2*SCALED_W-1:0] cc;
      logic [2:0][SCALED_W-1:0]   c;
      logic                       mxnz;
      logic [2:0]                 neg;
      logic [2:0][COORD_W-1:0]    ctc;
      logic [MAG_W-1:0]           rsum;
   } st5_type;

   typedef struct packed {
      logic                     hit;
      logic [2:0][SCALED_W-1:0] c;
      logic                     mxnz;
      logic [2:0]               neg;
      logic [2:0][COORD_W-1:0]  ctc;
      logic [MAG_W-1:0]         rsum;
   } sqside_type;

   typedef struct packed {
      logic                    hit;
      logic                    mxnz;
      logic [2:0]              neg;
      logic [2:0][COORD_W-1:0] ctc;
      logic [MAG_W-1:0]        depth;
   } divside_type;

   typedef struct packed {
      logic                    hit;
      logic [2:0][COORD_W-1:0] normal;
      logic [2:0][COORD_W-1:0] contact;
      logic [MAG_W-1:0]        depth;
   } result_type;

   // leading zero count by binary search, input assumed nonzero
   function automatic logic [SHIFT_W-1:0] lead_zeros(input logic [31:0] y);
      logic [31:0]        t;
      logic [SHIFT_W-1:0] n;
      t = y;
      n = '0;
      if (t[31:16] == 16'h0) begin
         n[4] = 1'b1;
         t = {t[15:0], 16'h0};
      end
      if (t[31:24] == 8'h0) begin
         n[3] = 1'b1;
         t = {t[23:0], 8'h0};
      end
      if (t[31:28] == 4'h0) begin
         n[2] = 1'b1;
         t = {t[27:0], 4'h0};
      end
      if (t[31:30] == 2'h0) begin
         n[1] = 1'b1;
         t = {t[29:0], 2'h0};
      end
      if (t[31] == 1'b0) begin
         n[0] = 1'b1;
      end
      return n;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/sscon_if.sv =====
// ----------------------------------------------------------------------------
// sscon_if
// Valid/ready channels for sphere pairs and their contact results.
// ----------------------------------------------------------------------------
`default_nettype none

interface sscon_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] center_a_x;
   logic [31:0] center_a_y;
   logic [31:0] center_a_z;
   logic [31:0] center_b_x;
   logic [31:0] center_b_y;
   logic [31:0] center_b_z;
   logic [30:0] radius_a;
   logic [30:0] radius_b;

   modport source (output valid, center_a_x, center_a_y, center_a_z,
                   center_b_x, center_b_y, center_b_z, radius_a, radius_b,
                   input ready);
   modport sink (input valid, center_a_x, center_a_y, center_a_z,
                 center_b_x, center_b_y, center_b_z, radius_a, radius_b,
                 output ready);
endinterface

interface sscon_rsp_if;
   logic        valid;
   logic        ready;
   logic        hit;
   logic [31:0] normal_x;
   logic [31:0] normal_y;
   logic [31:0] normal_z;
   logic [31:0] contact_x;
   logic [31:0] contact_y;
   logic [31:0] contact_z;
   logic [31:0] depth;

   modport source (output valid, hit, normal_x, normal_y, normal_z,
                   contact_x, contact_y, contact_z, depth, input ready);
   modport sink (input valid, hit, normal_x, normal_y, normal_z,
                 contact_x, contact_y, contact_z, depth, output ready);
endinterface

`default_nettype wire

// ===== rtl/sscon_sqrt.sv =====
// ----------------------------------------------------------------------------
// sscon_sqrt
// Pipelined integer square root, one root bit per stage, with remainder.
// ----------------------------------------------------------------------------
`default_nettype none

module sscon_sqrt #(
   parameter int LANES  = 2,
   parameter int SIDE_W = 1
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  enable,
   input  wire logic                                  in_valid,
   input  wire logic [LANES-1:0][sscon_pkg::SQ_W-1:0] in_rad,
   input  wire logic [SIDE_W-1:0]                     in_side,
   output logic                                       out_valid,
   output logic [LANES-1:0][sscon_pkg::ROOT_W-1:0]    out_root,
   output logic [LANES-1:0][sscon_pkg::ROOT_W:0]      out_rem,
   output logic [SIDE_W-1:0]                          out_side
);

   localparam int STEPS = sscon_pkg::ROOT_W;
   localparam int REM_W = sscon_pkg::ROOT_W + 2;

   logic [STEPS-1:0]                                 v_ff;
   logic [STEPS-1:0][LANES-1:0][sscon_pkg::SQ_W-1:0] rad_ff;
   logic [STEPS-1:0][LANES-1:0][REM_W-1:0]           rem_ff;
   logic [STEPS-1:0][LANES-1:0][sscon_pkg::ROOT_W-1:0] root_ff;
   logic [STEPS-1:0][SIDE_W-1:0]                     side_ff;

   for (genvar k = 0; k < STEPS; k++) begin : g_step
      localparam int P = STEPS - 1 - k;
      logic                                  v_p;
      logic [LANES-1:0][sscon_pkg::SQ_W-1:0] rad_p;
      logic [LANES-1:0][REM_W-1:0]           rem_p;
      logic [LANES-1:0][sscon_pkg::ROOT_W-1:0] root_p;
      logic [SIDE_W-1:0]                     side_p;
      logic [LANES-1:0][REM_W-1:0]           rem_in;
      logic [LANES-1:0][sscon_pkg::ROOT_W-1:0] root_in;

      if (k == 0) begin : g_first
         assign v_p    = in_valid;
         assign rad_p  = in_rad;
         assign rem_p  = '0;
         assign root_p = '0;
         assign side_p = in_side;
      end else begin : g_next
         assign v_p    = v_ff[k-1];
         assign rad_p  = rad_ff[k-1];
         assign rem_p  = rem_ff[k-1];
         assign root_p = root_ff[k-1];
         assign side_p = side_ff[k-1];
      end

      always_comb begin
         logic [REM_W+1:0] r_sh;
         logic [REM_W+1:0] trial;
         logic             ge;
         for (int l = 0; l < LANES; l++) begin
            r_sh  = {rem_p[l], rad_p[l][2*P+1 -: 2]};
            trial = {2'b00, root_p[l], 2'b01};
            ge    = (r_sh >= trial);
            rem_in[l]  = ge ? REM_W'(r_sh - trial) : REM_W'(r_sh);
            root_in[l] = {root_p[l][sscon_pkg::ROOT_W-2:0], ge};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k] <= 1'b0;
         end else if (enable) begin
            v_ff[k] <= v_p;
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            rad_ff[k]  <= rad_p;
            rem_ff[k]  <= rem_in;
            root_ff[k] <= root_in;
            side_ff[k] <= side_p;
         end
      end
   end

   assign out_valid = v_ff[STEPS-1];
   assign out_root  = root_ff[STEPS-1];
   assign out_side  = side_ff[STEPS-1];

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         out_rem[l] = rem_ff[STEPS-1][l][sscon_pkg::ROOT_W:0];
      end
   end

endmodule

`default_nettype wire

// ===== rtl/sscon_div.sv =====
// ----------------------------------------------------------------------------
// sscon_div
// Pipelined restoring divider for the normal: one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module sscon_div #(
   parameter int LANES  = 3,
   parameter int SIDE_W = 1
) (
   input  wire logic                                      clock,
   input  wire logic                                      reset,
   input  wire logic                                      enable,
   input  wire logic                                      in_valid,
   input  wire logic [sscon_pkg::ROOT_W-1:0]              in_divisor,
   input  wire logic [LANES-1:0][sscon_pkg::SCALED_W-2:0] in_top,
   input  wire logic [LANES-1:0]                          in_bit,
   input  wire logic [SIDE_W-1:0]                         in_side,
   output logic                                           out_valid,
   output logic [LANES-1:0][sscon_pkg::QUOT_W-1:0]        out_quot,
   output logic [SIDE_W-1:0]                              out_side
);

   localparam int STEPS = sscon_pkg::QUOT_W;
   localparam int D_W   = sscon_pkg::ROOT_W;

   logic [STEPS-1:0]                                   v_ff;
   logic [STEPS-1:0][D_W-1:0]                          dv_ff;
   logic [STEPS-1:0][LANES-1:0][D_W-1:0]               rem_ff;
   logic [STEPS-1:0][LANES-1:0][sscon_pkg::QUOT_W-1:0] q_ff;
   logic [STEPS-1:0][SIDE_W-1:0]                       side_ff;

   for (genvar j = 0; j < STEPS; j++) begin : g_step
      logic                                   v_p;
      logic [D_W-1:0]                         dv_p;
      logic [LANES-1:0][D_W-1:0]              rem_p;
      logic [LANES-1:0][sscon_pkg::QUOT_W-1:0] q_p;
      logic [LANES-1:0]                       b_p;
      logic [SIDE_W-1:0]                      side_p;
      logic [LANES-1:0][D_W-1:0]              rem_in;
      logic [LANES-1:0][sscon_pkg::QUOT_W-1:0] q_in;

      if (j == 0) begin : g_first
         assign v_p    = in_valid;
         assign dv_p   = in_divisor;
         assign q_p    = '0;
         assign b_p    = in_bit;
         assign side_p = in_side;
         always_comb begin
            for (int l = 0; l < LANES; l++) begin
               rem_p[l] = D_W'(in_top[l]);
            end
         end
      end else begin : g_next
         // only zeros remain below the lowest dividend bit
         assign v_p    = v_ff[j-1];
         assign dv_p   = dv_ff[j-1];
         assign rem_p  = rem_ff[j-1];
         assign q_p    = q_ff[j-1];
         assign b_p    = '0;
         assign side_p = side_ff[j-1];
      end

      always_comb begin
         logic [D_W:0] sh;
         logic         ge;
         for (int l = 0; l < LANES; l++) begin
            sh = {rem_p[l], b_p[l]};
            ge = (sh >= {1'b0, dv_p});
            rem_in[l] = ge ? D_W'(sh - {1'b0, dv_p}) : D_W'(sh);
            q_in[l]   = {q_p[l][sscon_pkg::QUOT_W-2:0], ge};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[j] <= 1'b0;
         end else if (enable) begin
            v_ff[j] <= v_p;
         end
      end

      always_ff @(posedge clock) begin
         if (enable) begin
            dv_ff[j]   <= dv_p;
            rem_ff[j]  <= rem_in;
            q_ff[j]    <= q_in;
            side_ff[j] <= side_p;
         end
      end
   end

   assign out_valid = v_ff[STEPS-1];
   assign out_quot  = q_ff[STEPS-1];
   assign out_side  = side_ff[STEPS-1];

endmodule

`default_nettype wire

// ===== rtl/sscon_skid.sv =====
// ----------------------------------------------------------------------------
// sscon_skid
// Output register with one skid entry; holds the pipeline while it is full.
// ----------------------------------------------------------------------------
`default_nettype none

module sscon_skid (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   in_valid,
   input  wire sscon_pkg::result_type  in_data,
   output logic                        pipe_en,
   output logic                        out_valid,
   input  wire logic                   out_ready,
   output sscon_pkg::result_type       out_data
);

   logic                  out_v_ff;
   logic                  out_v_in;
   logic                  skid_v_ff;
   logic                  skid_v_in;
   sscon_pkg::result_type out_d_ff;
   sscon_pkg::result_type out_d_in;
   sscon_pkg::result_type skid_d_ff;
   sscon_pkg::result_type skid_d_in;
   logic                  take;
   logic                  arrive;

   assign pipe_en = ~skid_v_ff;
   assign arrive  = in_valid & pipe_en;
   assign take    = ~out_v_ff | out_ready;

   always_comb begin
      out_v_in  = out_v_ff;
      out_d_in  = out_d_ff;
      skid_v_in = skid_v_ff;
      skid_d_in = skid_d_ff;
      if (take) begin
         if (skid_v_ff) begin
            out_v_in  = 1'b1;
            out_d_in  = skid_d_ff;
            skid_v_in = 1'b0;
         end else begin
            out_v_in = arrive;
            out_d_in = in_data;
         end
      end else if (arrive) begin
         // park the transaction while the receiver stalls
         skid_v_in = 1'b1;
         skid_d_in = in_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else begin
         out_v_ff  <= out_v_in;
         skid_v_ff <= skid_v_in;
      end
   end

   always_ff @(posedge clock) begin
      out_d_ff  <= out_d_in;
      skid_d_ff <= skid_d_in;
   end

   assign out_valid = out_v_ff;
   assign out_data  = out_d_ff;

endmodule

`default_nettype wire

// ===== rtl/sphere_sphere_contact.sv =====
// ----------------------------------------------------------------------------
// sphere_sphere_contact
// Sphere pair overlap test with normal, midpoint contact and depth.
// ----------------------------------------------------------------------------
// Usage: present a sphere pair (two Q16.16 centers, two radii) on req; it is
// taken when req.valid and req.ready are high at a rising clock edge. Each
// pair yields exactly one transaction on rsp, in order: hit, unit normal
// (Q2.30), contact midpoint and penetration depth; every field but hit is
// zero when the spheres do not overlap.
// Throughput: one pair per cycle while not stalled (see Stalls). A pair
// passes six front stages (difference, squares, sum, scaling), a 32-stage
// square root holding both lengths and a 31-stage divider that forms the
// three normal components, then the output register, to reach rsp.valid.
// Stalls: an output register and one skid entry sit at the end; when the
// receiver holds rsp.ready low the skid entry fills and the whole pipeline
// holds, dropping req.ready, until the skid entry drains.
// Reset: synchronous; clears all valid bits, nothing else needs clearing.
// ----------------------------------------------------------------------------
`default_nettype none

module sphere_sphere_contact (
   input  wire logic  clock,
   input  wire logic  reset,
   sscon_req_if.sink  req,
   sscon_rsp_if.source rsp
);

   logic                pe;
   logic                v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff;
   sscon_pkg::st1_type  s1_ff, s1_in;
   sscon_pkg::st2_type  s2_ff, s2_in;
   sscon_pkg::st3_type  s3_ff, s3_in;
   sscon_pkg::st4_type  s4_ff, s4_in;
   sscon_pkg::st5_type  s5_ff, s5_in;
   logic [1:0][sscon_pkg::SQ_W-1:0] rad6_ff, rad6_in;
   sscon_pkg::sqside_type           side6_ff, side6_in;

   logic [2:0][31:0] ca;
   logic [2:0][31:0] cb;

   assign ca = {req.center_a_z, req.center_a_y, req.center_a_x};
   assign cb = {req.center_b_z, req.center_b_y, req.center_b_x};
   assign req.ready = pe;

   // stage 1: offset, magnitude, midpoint, radius sum
   always_comb begin
      logic [32:0] a33, b33, diff, sum, ndiff;
      for (int i = 0; i < 3; i++) begin
         a33   = {ca[i][31], ca[i]};
         b33   = {cb[i][31], cb[i]};
         diff  = b33 - a33;
         ndiff = 33'd0 - diff;
         sum   = a33 + b33;
         s1_in.neg[i] = diff[32];
         s1_in.mag[i] = diff[32] ? ndiff[31:0] : diff[31:0];
         s1_in.ctc[i] = sum[32:1];
      end
      s1_in.rsum = {1'b0, req.radius_a} + {1'b0, req.radius_b};
   end

   // stage 2: squares and largest magnitude
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s2_in.sq[i] = s1_ff.mag[i] * s1_ff.mag[i];
      end
      s2_in.rsq = s1_ff.rsum * s1_ff.rsum;
      s2_in.mx  = s1_ff.mag[0];
      if (s1_ff.mag[1] > s2_in.mx) s2_in.mx = s1_ff.mag[1];
      if (s1_ff.mag[2] > s2_in.mx) s2_in.mx = s1_ff.mag[2];
      s2_in.mag  = s1_ff.mag;
      s2_in.neg  = s1_ff.neg;
      s2_in.ctc  = s1_ff.ctc;
      s2_in.rsum = s1_ff.rsum;
   end

   // stage 3: squared length and normalizing shift
   always_comb begin
      s3_in.lo = (sscon_pkg::SQ_W+2)'(s2_ff.sq[0]) + (sscon_pkg::SQ_W+2)'(s2_ff.sq[1])
               + (sscon_pkg::SQ_W+2)'(s2_ff.sq[2]);
      s3_in.rsq  = s2_ff.rsq;
      s3_in.mag  = s2_ff.mag;
      s3_in.down = s2_ff.mx[31];
      s3_in.up   = sscon_pkg::lead_zeros({s2_ff.mx[30:0], 1'b1});
      s3_in.mxnz = |s2_ff.mx;
      s3_in.neg  = s2_ff.neg;
      s3_in.ctc  = s2_ff.ctc;
      s3_in.rsum = s2_ff.rsum;
   end

   // stage 4: hit test and scaled offset
   always_comb begin
      s4_in.hit = (s3_ff.lo < {2'b00, s3_ff.rsq});
      s4_in.lo  = s3_ff.lo[sscon_pkg::SQ_W-1:0];
      for (int i = 0; i < 3; i++) begin
         s4_in.c[i] = s3_ff.down ? s3_ff.mag[i][31:1]
                                 : sscon_pkg::SCALED_W'(s3_ff.mag[i] << s3_ff.up);
      end
      s4_in.mxnz = s3_ff.mxnz;
      s4_in.neg  = s3_ff.neg;
      s4_in.ctc  = s3_ff.ctc;
      s4_in.rsum = s3_ff.rsum;
   end

   // stage 5: squares of the scaled offset
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         s5_in.cc[i] = s4_ff.c[i] * s4_ff.c[i];
      end
      s5_in.hit  = s4_ff.hit;
      s5_in.lo   = s4_ff.lo;
      s5_in.c    = s4_ff.c;
      s5_in.mxnz = s4_ff.mxnz;
      s5_in.neg  = s4_ff.neg;
      s5_in.ctc  = s4_ff.ctc;
      s5_in.rsum = s4_ff.rsum;
   end

   // stage 6: scaled squared length
   always_comb begin
      rad6_in[0] = s5_ff.lo;
      rad6_in[1] = sscon_pkg::SQ_W'(s5_ff.cc[0]) + sscon_pkg::SQ_W'(s5_ff.cc[1])
                 + sscon_pkg::SQ_W'(s5_ff.cc[2]);
      side6_in.hit  = s5_ff.hit;
      side6_in.c    = s5_ff.c;
      side6_in.mxnz = s5_ff.mxnz;
      side6_in.neg  = s5_ff.neg;
      side6_in.ctc  = s5_ff.ctc;
      side6_in.rsum = s5_ff.rsum;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else if (pe) begin
         v1_ff <= req.valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pe) begin
         s1_ff    <= s1_in;
         s2_ff    <= s2_in;
         s3_ff    <= s3_in;
         s4_ff    <= s4_in;
         s5_ff    <= s5_in;
         rad6_ff  <= rad6_in;
         side6_ff <= side6_in;
      end
   end

   // square roots of the true and the scaled squared length
   logic                                  sq_valid;
   logic [1:0][sscon_pkg::ROOT_W-1:0]     sq_root;
   logic [1:0][sscon_pkg::ROOT_W:0]       sq_rem;
   logic [$bits(sscon_pkg::sqside_type)-1:0] sq_side_vec;
   sscon_pkg::sqside_type                 sq_side;

   sscon_sqrt #(
      .LANES  (2),
      .SIDE_W ($bits(sscon_pkg::sqside_type))
   ) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .enable    (pe),
      .in_valid  (v6_ff),
      .in_rad    (rad6_ff),
      .in_side   (side6_ff),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_rem   (sq_rem),
      .out_side  (sq_side_vec)
   );

   assign sq_side = sscon_pkg::sqside_type'(sq_side_vec);

   // round the distance to nearest and form the depth
   sscon_pkg::divside_type            dv_side;
   logic [2:0][sscon_pkg::SCALED_W-2:0] dv_top;
   logic [2:0]                        dv_bit;

   always_comb begin
      logic rnd;
      rnd = (sq_rem[0] > {1'b0, sq_root[0]});
      dv_side.hit   = sq_side.hit;
      dv_side.mxnz  = sq_side.mxnz;
      dv_side.neg   = sq_side.neg;
      dv_side.ctc   = sq_side.ctc;
      dv_side.depth = sq_side.rsum - sq_root[0] - sscon_pkg::MAG_W'(rnd);
      for (int i = 0; i < 3; i++) begin
         dv_top[i] = sq_side.c[i][sscon_pkg::SCALED_W-1:1];
         dv_bit[i] = sq_side.c[i][0];
      end
   end

   logic                                  div_valid;
   logic [2:0][sscon_pkg::QUOT_W-1:0]     div_quot;
   logic [$bits(sscon_pkg::divside_type)-1:0] div_side_vec;
   sscon_pkg::divside_type                div_side;

   sscon_div #(
      .LANES  (3),
      .SIDE_W ($bits(sscon_pkg::divside_type))
   ) u_div (
      .clock      (clock),
      .reset      (reset),
      .enable     (pe),
      .in_valid   (sq_valid),
      .in_divisor (sq_root[1]),
      .in_top     (dv_top),
      .in_bit     (dv_bit),
      .in_side    (dv_side),
      .out_valid  (div_valid),
      .out_quot   (div_quot),
      .out_side   (div_side_vec)
   );

   assign div_side = sscon_pkg::divside_type'(div_side_vec);

   // apply signs, zero everything on a miss
   sscon_pkg::result_type res;

   always_comb begin
      logic [31:0] q32;
      res.hit = div_side.hit;
      for (int i = 0; i < 3; i++) begin
         q32 = {1'b0, div_quot[i]};
         if (div_side.hit && div_side.mxnz) begin
            res.normal[i] = div_side.neg[i] ? 32'd0 - q32 : q32;
         end else begin
            res.normal[i] = '0;
         end
         res.contact[i] = div_side.hit ? div_side.ctc[i] : '0;
      end
      res.depth = div_side.hit ? div_side.depth : '0;
   end

   sscon_pkg::result_type out_res;

   sscon_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (div_valid),
      .in_data   (res),
      .pipe_en   (pe),
      .out_valid (rsp.valid),
      .out_ready (rsp.ready),
      .out_data  (out_res)
   );

   assign rsp.hit       = out_res.hit;
   assign rsp.normal_x  = out_res.normal[0];
   assign rsp.normal_y  = out_res.normal[1];
   assign rsp.normal_z  = out_res.normal[2];
   assign rsp.contact_x = out_res.contact[0];
   assign rsp.contact_y = out_res.contact[1];
   assign rsp.contact_z = out_res.contact[2];
   assign rsp.depth     = out_res.depth;

endmodule

`default_nettype wire

// ===== tb/sscon_check.sv =====
// ----------------------------------------------------------------------------
// sscon_check
// Watches the sphere pair and contact result channels, predicts each result
// from the accepted pair and compares it field by field, in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sscon_check (
   input  logic        clock,
   input  logic        reset,
   sscon_req_if.sink   req_mon,
   sscon_rsp_if.sink   rsp_mon,
   output int          fail_count,
   output int          pending_count
);

   sscon_pkg::result_type contact_queue[$];

   function automatic logic [63:0] floor_root(input logic [63:0] v);
      logic [63:0] r;
      logic [63:0] b;
      logic [63:0] x;
      x = v;
      r = '0;
      b = 64'h1 << 62;
      while (b > x) b = b >> 2;
      while (b != 0) begin
         if (x >= r + b) begin
            x = x - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic sscon_pkg::result_type predict_contact(
      input logic [2:0][31:0] ca, input logic [2:0][31:0] cb,
      input logic [30:0] ra, input logic [30:0] rb);
      sscon_pkg::result_type res;
      logic signed [33:0] d [3];
      logic signed [33:0] s;
      logic [63:0] m [3];
      logic [63:0] c [3];
      logic [65:0] d2;
      logic [63:0] rsum, rsq, r, mx, sc, len, q;
      int up;
      res = '0;
      d2 = '0;
      for (int i = 0; i < 3; i++) begin
         d[i] = $signed(cb[i]) - $signed(ca[i]);
         m[i] = d[i] < 0 ? 64'(-d[i]) : 64'(d[i]);
         d2 = d2 + m[i] * m[i];
      end
      rsum = 64'(ra) + 64'(rb);
      rsq = rsum * rsum;
      if (d2[65:64] != 0 || d2[63:0] >= rsq) return res;
      res.hit = 1'b1;
      for (int i = 0; i < 3; i++) begin
         s = $signed(ca[i]) + $signed(cb[i]);
         res.contact[i] = 32'(s >>> 1);
      end
      r = floor_root(d2[63:0]);
      if (d2[63:0] - r * r > r) r = r + 1;
      res.depth = 32'(rsum - r);
      mx = m[0];
      if (m[1] > mx) mx = m[1];
      if (m[2] > mx) mx = m[2];
      if (mx != 0) begin
         up = 0;
         if (mx < 64'h8000_0000) while ((mx << up) < 64'h4000_0000) up++;
         sc = '0;
         for (int i = 0; i < 3; i++) begin
            c[i] = mx >= 64'h8000_0000 ? m[i] >> 1 : m[i] << up;
            sc = sc + c[i] * c[i];
         end
         len = floor_root(sc);
         for (int i = 0; i < 3; i++) begin
            q = (c[i] << 30) / len;
            res.normal[i] = d[i] < 0 ? 32'(-q) : 32'(q);
         end
      end
      return res;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t: mismatch on %s: got %h, want %h", $time, what, got, want);
      fail_count++;
   endtask

   initial fail_count = 0;
   initial pending_count = 0;

   always @(posedge clock) begin
      sscon_pkg::result_type want;
      if (!reset) begin
         if (req_mon.valid && req_mon.ready)
            contact_queue.push_back(predict_contact(
               {req_mon.center_a_z, req_mon.center_a_y, req_mon.center_a_x},
               {req_mon.center_b_z, req_mon.center_b_y, req_mon.center_b_x},
               req_mon.radius_a, req_mon.radius_b));
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (contact_queue.size() == 0) begin
               report_mismatch("unexpected transaction", 32'(rsp_mon.hit), '0);
            end else begin
               want = contact_queue.pop_front();
               if (rsp_mon.hit !== want.hit)
                  report_mismatch("hit", 32'(rsp_mon.hit), 32'(want.hit));
               if (rsp_mon.normal_x !== want.normal[0])
                  report_mismatch("normal_x", rsp_mon.normal_x, want.normal[0]);
               if (rsp_mon.normal_y !== want.normal[1])
                  report_mismatch("normal_y", rsp_mon.normal_y, want.normal[1]);
               if (rsp_mon.normal_z !== want.normal[2])
                  report_mismatch("normal_z", rsp_mon.normal_z, want.normal[2]);
               if (rsp_mon.contact_x !== want.contact[0])
                  report_mismatch("contact_x", rsp_mon.contact_x, want.contact[0]);
               if (rsp_mon.contact_y !== want.contact[1])
                  report_mismatch("contact_y", rsp_mon.contact_y, want.contact[1]);
               if (rsp_mon.contact_z !== want.contact[2])
                  report_mismatch("contact_z", rsp_mon.contact_z, want.contact[2]);
               if (rsp_mon.depth !== want.depth)
                  report_mismatch("depth", rsp_mon.depth, want.depth);
            end
         end
      end
      pending_count = contact_queue.size();
   end

endmodule

// ===== tb/sphere_sphere_contact_tb.sv =====
// ----------------------------------------------------------------------------
// sphere_sphere_contact_tb
// Drives directed and random sphere pairs with random idle bursts on both
// channels; a checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sphere_sphere_contact_tb;

   localparam int LATENCY = 70;

   logic clock;
   logic reset;
   int   fail_count;
   int   pending_count;
   bit   rsp_idle_on;

   sscon_req_if req_ch ();
   sscon_rsp_if rsp_ch ();

   sphere_sphere_contact DUT (
      .clock (clock),
      .reset (reset),
      .req   (req_ch.sink),
      .rsp   (rsp_ch.source)
   );

   sscon_check checker_inst (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_ch.sink),
      .rsp_mon       (rsp_ch.sink),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // random-content coordinate: mostly near a small cluster, sometimes anything
   function automatic logic [31:0] any_coord(input logic [31:0] base, input int mode);
      case (mode)
         0: return $urandom();
         1: return base + 32'($signed($urandom_range(0, 32'h0003_FFFF)) - 32'h0001_FFFF);
         default: return base + 32'($signed($urandom_range(0, 32'h00FF_FFFF)) - 32'h007F_FFFF);
      endcase
   endfunction

   task automatic send_pair(input logic [31:0] ax, ay, az, bx, by, bz,
                            input logic [30:0] ra, rb, input bit idles);
      int gap;
      if (idles && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 10);
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid      <= 1'b1;
      req_ch.center_a_x <= ax;
      req_ch.center_a_y <= ay;
      req_ch.center_a_z <= az;
      req_ch.center_b_x <= bx;
      req_ch.center_b_y <= by;
      req_ch.center_b_z <= bz;
      req_ch.radius_a   <= ra;
      req_ch.radius_b   <= rb;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic send_random(input bit idles);
      logic [31:0] ax, ay, az, bx, by, bz;
      logic [30:0] ra, rb;
      int mode;
      mode = $urandom_range(0, 9);
      ax = $urandom();
      ay = $urandom();
      az = $urandom();
      if (mode == 0) begin
         bx = $urandom(); by = $urandom(); bz = $urandom();
         ra = $urandom(); rb = $urandom();
      end else begin
         bx = any_coord(ax, mode % 3);
         by = any_coord(ay, mode % 3);
         bz = any_coord(az, mode % 3);
         if (mode == 9) begin
            bx = ax; by = ay; bz = az;
         end
         ra = (mode % 2) ? 31'($urandom_range(0, 32'h00FF_FFFF)) : 31'($urandom());
         rb = (mode % 4 == 1) ? 31'($urandom_range(0, 32'h0003_FFFF)) : 31'($urandom());
      end
      send_pair(ax, ay, az, bx, by, bz, ra, rb, idles);
   endtask

   // sink side stalls in bursts until switched off
   initial begin
      rsp_ch.ready = 1'b0;
      @(negedge clock);
      forever begin
         if (rsp_idle_on && $urandom_range(0, 3) == 0) begin
            rsp_ch.ready <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clock);
         end
         rsp_ch.ready <= 1'b1;
         repeat ($urandom_range(1, 12)) @(negedge clock);
      end
   end

   initial begin
      #2_000_000;
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      req_ch.valid      = 1'b0;
      req_ch.center_a_x = '0;
      req_ch.center_a_y = '0;
      req_ch.center_a_z = '0;
      req_ch.center_b_x = '0;
      req_ch.center_b_y = '0;
      req_ch.center_b_z = '0;
      req_ch.radius_a   = '0;
      req_ch.radius_b   = '0;
      rsp_idle_on       = 1'b1;
      reset             = 1'b1;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // extremes, coincident centers, zero radius sum, touching, far apart
      send_pair('0, '0, '0, '0, '0, '0, '0, '0, 0);
      send_pair('0, '0, '0, '0, '0, '0, 31'h1, '0, 0);
      send_pair(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                31'h7FFF_FFFF, 31'h7FFF_FFFF, 0);
      send_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                31'h7FFF_FFFF, 31'h7FFF_FFFF, 0);
      send_pair(32'h8000_0000, '0, '0, 32'h7FFF_FFFF, '0, '0,
                31'h7FFF_FFFF, 31'h7FFF_FFFF, 0);
      send_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 31'h7FFF_FFFF, '0, 0);
      send_pair('0, '0, '0, 32'h0002_0000, '0, '0, 31'h0001_0000, 31'h0001_0000, 0);
      send_pair('0, '0, '0, 32'h0002_0000, '0, '0, 31'h0001_0000, 31'h0001_0001, 0);
      send_pair('0, '0, '0, '0, 32'hFFFF_FFFF, '0, 31'h1, 31'h1, 0);
      send_pair('0, '0, '0, '0, '0, 32'h0000_0001, 31'h1, '0, 0);
      send_pair(32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000,
                32'hFFFF_0001, 32'h0001_0000, 32'hFFFF_8000,
                31'h0003_0000, 31'h0002_0000, 0);
      send_pair(32'h7FFF_FFFF, '0, '0, 32'h8000_0000, '0, '0, 31'h7FFF_FFFF, 31'h1, 0);
      send_pair(32'h1234_5678, 32'h8765_4321, 32'h0F0F_0F0F,
                32'h1234_5679, 32'h8765_4320, 32'h0F0F_0F10,
                31'h5555_5555, 31'h2AAA_AAAA, 0);

      for (int n = 0; n < 800; n++) send_random(1);
      // hold until the pipeline has drained
      req_ch.valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      for (int n = 0; n < 750; n++) send_random(1);
      rsp_idle_on = 1'b0;
      for (int n = 0; n < 200; n++) send_random(0);
      req_ch.valid <= 1'b0;

      while (pending_count != 0) @(negedge clock);
      repeat (LATENCY + 10) @(negedge clock);
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/sscon_pkg.sv
rtl/sscon_if.sv
rtl/sscon_sqrt.sv
rtl/sscon_div.sv
rtl/sscon_skid.sv
rtl/sphere_sphere_contact.sv
tb/sscon_check.sv
tb/sphere_sphere_contact_tb.sv
